// ----- hdl/lbs_pkg.sv -----
package lbs_pkg;

	localparam int unsigned TickW  = 16;
	localparam int unsigned CountW = 8;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [TickW-1:0] OnTicksRst    = 16'd100;
	localparam logic [TickW-1:0] OffTicksRst   = 16'd400;
	localparam logic [TickW-1:0] PauseTicksRst = 16'd2000;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_GREEN = 2'd2,
		OP_RED   = 2'd3
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ON    = 2'd0,
		CFG_OFF   = 2'd1,
		CFG_PAUSE = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_ON    = 4'b0010,
		PH_OFF   = 4'b0100,
		PH_PAUSE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [TickW-1:0] on_ticks;
		logic [TickW-1:0] off_ticks;
		logic [TickW-1:0] pause_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [TickW-1:0]  tick_counter;
		logic [CountW-1:0] blinks_done;
		logic [CountW-1:0] target_blinks;
		logic              repeat_flag;
		logic              green_level;
		logic              red_level;
	} seq_state_t;

endpackage

// ----- hdl/lbs_cfg.sv -----
module lbs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lbs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lbs_pkg::TickW-1:0]    cfg_data,
	output lbs_pkg::cfg_t                cfg
);
	import lbs_pkg::*;

	cfg_t cfg_q;

	// Drop writes to indexes beyond the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks    <= OnTicksRst;
			cfg_q.off_ticks   <= OffTicksRst;
			cfg_q.pause_ticks <= PauseTicksRst;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ON:    cfg_q.on_ticks    <= cfg_data;
				CFG_OFF:   cfg_q.off_ticks   <= cfg_data;
				CFG_PAUSE: cfg_q.pause_ticks <= cfg_data;
				default:   ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/lbs_step.sv -----
module lbs_step (
	input  lbs_pkg::seq_state_t          cur,
	input  lbs_pkg::cfg_t                cfg,
	input  logic [1:0]                   operation,
	input  logic [lbs_pkg::CountW-1:0]   blink_count,
	input  logic                         repeat_mode,
	input  logic                         level,
	output lbs_pkg::seq_state_t          nxt
);
	import lbs_pkg::*;

	logic [TickW-1:0]  dur;
	logic [TickW-1:0]  len;
	logic [TickW-1:0]  cnt_inc;
	logic [CountW-1:0] done_inc;
	logic              phase_end;

	// Length of the running phase; a zero register acts as one tick.
	always_comb begin
		case (cur.phase)
			PH_ON:   dur = cfg.on_ticks;
			PH_OFF:  dur = cfg.off_ticks;
			default: dur = cfg.pause_ticks;
		endcase
		len = (dur == '0) ? TickW'(1) : dur;
	end

	assign cnt_inc   = cur.tick_counter + TickW'(1);
	assign done_inc  = cur.blinks_done + CountW'(1);
	assign phase_end = (cnt_inc >= len);

	always_comb begin
		nxt = cur;
		case (op_t'(operation))
			OP_TICK: begin
				if (cur.phase != PH_IDLE) begin
					if (!phase_end) begin
						nxt.tick_counter = cnt_inc;
					end else begin
						nxt.tick_counter = '0;
						case (cur.phase)
							PH_ON: begin
								nxt.green_level = 1'b0;
								nxt.phase       = PH_OFF;
							end
							PH_OFF: begin
								if (done_inc < cur.target_blinks) begin
									nxt.blinks_done = done_inc;
									nxt.green_level = 1'b1;
									nxt.phase       = PH_ON;
								end else if (cur.repeat_flag) begin
									nxt.blinks_done = done_inc;
									nxt.phase       = PH_PAUSE;
								end else begin
									nxt.blinks_done = '0;
									nxt.phase       = PH_IDLE;
								end
							end
							PH_PAUSE: begin
								nxt.blinks_done = '0;
								nxt.green_level = 1'b1;
								nxt.phase       = PH_ON;
							end
							default: nxt.phase = PH_IDLE;
						endcase
					end
				end
			end
			OP_START: begin
				nxt.target_blinks = (blink_count == '0) ? CountW'(1) : blink_count;
				nxt.repeat_flag   = repeat_mode;
				nxt.blinks_done   = '0;
				nxt.green_level   = 1'b1;
				nxt.phase         = PH_ON;
				nxt.tick_counter  = '0;
			end
			OP_GREEN: nxt.green_level = level;
			OP_RED:   nxt.red_level   = level;
			default:  nxt = cur;
		endcase
	end

endmodule

// ----- hdl/led_blink_sequencer_core.sv -----
// Each result passes through the input register, then the result register.
// Throughput: one item per cycle unless the result register stalls; the sequencer state
// updates in the same cycle that the result register loads, so the next held item already sees it.
// Reset (arst_n low, asynchronous): phase idle, counters zero, both LED levels dark,
// timing registers back to 100 / 400 / 2000 ticks, both pipeline stages empty.
module led_blink_sequencer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// input item channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [lbs_pkg::CountW-1:0]   blink_count,
	input  logic                         repeat_mode,
	input  logic                         level,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         green_led,
	output logic                         red_led,
	output logic                         busy_res,
	// configuration write port
	input  logic                         cfg_we,
	input  logic [lbs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lbs_pkg::TickW-1:0]    cfg_data
);
	import lbs_pkg::*;

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;

	// Input register stage.
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [CountW-1:0] count_s1;
	logic              repeat_s1;
	logic              level_s1;

	// Result register.
	logic out_valid_q;
	logic green_q;
	logic red_q;
	logic busy_q;

	logic advance;

	// The held item moves on when the result register is empty or drains this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	// Accept a new transfer whenever the input register is empty or being emptied.
	assign in_ready = !valid_s1 || advance;

	lbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lbs_step u_step (
		.cur         (state_q),
		.cfg         (cfg),
		.operation   (op_s1),
		.blink_count (count_s1),
		.repeat_mode (repeat_s1),
		.level       (level_s1),
		.nxt         (state_nxt)
	);

	// Capture the input transfer; payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= operation;
			count_s1  <= blink_count;
			repeat_s1 <= repeat_mode;
			level_s1  <= level;
		end
	end

	// Advance the sequencer state once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.tick_counter  <= '0;
			state_q.blinks_done   <= '0;
			state_q.target_blinks <= '0;
			state_q.repeat_flag   <= 1'b0;
			state_q.green_level   <= 1'b0;
			state_q.red_level     <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Load the result with the state left behind by this item; hold it until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			green_q <= state_nxt.green_level;
			red_q   <= state_nxt.red_level;
			busy_q  <= (state_nxt.phase != PH_IDLE);
		end
	end

	assign out_valid = out_valid_q;
	assign green_led = green_q;
	assign red_led   = red_q;
	assign busy_res  = busy_q;

`ifndef NO_ASSERTIONS
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.phase))
		else $error("sequencer phase is not one-hot");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_IDLE) |-> (state_q.blinks_done == '0))
		else $error("blink count left over in idle");

	a_running_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase != PH_IDLE) |-> (state_q.target_blinks != '0))
		else $error("sequence running with zero blink target");

	a_start_enters_on: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == OP_START)) |=>
			(state_q.phase == PH_ON && state_q.tick_counter == '0 && busy_res))
		else $error("start did not enter the on phase");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(op_s1)))
		else $error("stalled item lost from input register");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lbs_pkg::*;

	// Two register stages sit between an input transfer and its result.
	localparam int PipeDepth = 2;
	// Register index that decodes to nothing; a write to it must leave all timing alone.
	localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
	localparam int NumRows = 33;
	localparam int NumPhases = 8;
	localparam int ItemsPerPhase = 65;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		logic green;
		logic red;
		logic busy;
	} leds_t;

	// One line of the directed table: an input item or a register write.
	// Where typed is set, leds holds the result worked out by hand.
	typedef struct packed {
		row_kind_t          kind;
		op_t                op;
		logic [CountW-1:0]  cnt;
		logic               rep;
		logic               lvl;
		logic [CfgIdxW-1:0] idx;
		logic [TickW-1:0]   data;
		logic               typed;
		leds_t              leds;
	} row_t;

	localparam row_t DIRECTED [NumRows] = '{
		// idle block: a tick changes nothing, set operations drive the levels
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b1, 3'b000},
		'{ROW_ITEM, OP_RED,   8'h00, 1'b0, 1'b1, CFG_ON,    16'h0000, 1'b1, 3'b010},
		'{ROW_ITEM, OP_GREEN, 8'h00, 1'b0, 1'b1, CFG_ON,    16'h0000, 1'b1, 3'b110},
		'{ROW_ITEM, OP_RED,   8'hFF, 1'b1, 1'b0, CFG_ON,    16'h0000, 1'b1, 3'b100},
		'{ROW_ITEM, OP_GREEN, 8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b1, 3'b000},
		// count of zero still runs one blink
		'{ROW_ITEM, OP_START, 8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b1, 3'b101},
		// force green dark while the sequence runs
		'{ROW_ITEM, OP_GREEN, 8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b1, 3'b001},
		'{ROW_ITEM, OP_START, 8'hFF, 1'b1, 1'b1, CFG_ON,    16'h0000, 1'b1, 3'b101},
		'{ROW_ITEM, OP_TICK,  8'hFF, 1'b1, 1'b1, CFG_ON,    16'h0000, 1'b0, 3'b000},
		// zero durations act as one tick; the spare index is ignored
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_OFF,   16'h0001, 1'b0, 3'b000},
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_PAUSE, 16'h0000, 1'b0, 3'b000},
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CfgSpare,  16'hFFFF, 1'b0, 3'b000},
		// restart of a running sequence
		'{ROW_ITEM, OP_START, 8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b1, 3'b101},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		// two blinks in repeat mode, with green forced on during a dark phase
		'{ROW_ITEM, OP_START, 8'h02, 1'b1, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_GREEN, 8'h00, 1'b0, 1'b1, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		// longest durations, then on-time lowered below the running count
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'hFFFF, 1'b0, 3'b000},
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_OFF,   16'hFFFF, 1'b0, 3'b000},
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_PAUSE, 16'hFFFF, 1'b0, 3'b000},
		'{ROW_ITEM, OP_START, 8'h01, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000},
		'{ROW_REG,  OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0002, 1'b0, 3'b000},
		'{ROW_ITEM, OP_TICK,  8'h00, 1'b0, 1'b0, CFG_ON,    16'h0000, 1'b0, 3'b000}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          operation = OP_TICK;
	logic [CountW-1:0]   blink_count = '0;
	logic                repeat_mode = 1'b0;
	logic                level = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                green_led;
	logic                red_led;
	logic                busy_res;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = CFG_ON;
	logic [TickW-1:0]    cfg_data = '0;

	// Shadow of the sequencer: timing registers and state, both at reset values.
	logic [TickW-1:0]  on_len = OnTicksRst;
	logic [TickW-1:0]  off_len = OffTicksRst;
	logic [TickW-1:0]  pause_len = PauseTicksRst;
	phase_t            seq_phase = PH_IDLE;
	logic [TickW-1:0]  seq_ticks = '0;
	logic [CountW-1:0] seq_done = '0;
	logic [CountW-1:0] seq_target = '0;
	logic              seq_repeat = 1'b0;
	logic              green_lvl = 1'b0;
	logic              red_lvl = 1'b0;

	leds_t expected_leds [$];
	int    errors = 0;
	int    send_gap_pct = 0;
	int    recv_stall_pct = 0;
	bit    in_flight = 1'b0;

	led_blink_sequencer_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.blink_count (blink_count),
		.repeat_mode (repeat_mode),
		.level       (level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.green_led   (green_led),
		.red_led     (red_led),
		.busy_res    (busy_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	// Apply one accepted item to the shadow sequencer and return the LED state after it.
	task automatic advance_sequencer(input op_t op, input logic [CountW-1:0] cnt,
			input logic rep, input logic lvl, output leds_t leds);
		logic [TickW-1:0] len;
		case (op)
			OP_TICK: begin
				// Ticks only count while a phase runs; an idle block ignores them.
				if (seq_phase != PH_IDLE) begin
					seq_ticks = seq_ticks + 1'b1;
					case (seq_phase)
						PH_ON:   len = on_len;
						PH_OFF:  len = off_len;
						default: len = pause_len;
					endcase
					// A zero duration still lasts one tick.
					if (len == '0)
						len = TickW'(1);
					// Compare with >= so a duration lowered mid-phase ends it at once.
					if (seq_ticks >= len) begin
						seq_ticks = '0;
						case (seq_phase)
							PH_ON: begin
								green_lvl = 1'b0;
								seq_phase = PH_OFF;
							end
							PH_OFF: begin
								seq_done = seq_done + 1'b1;
								if (seq_done < seq_target) begin
									green_lvl = 1'b1;
									seq_phase = PH_ON;
								end else if (seq_repeat) begin
									seq_phase = PH_PAUSE;
								end else begin
									seq_done = '0;
									seq_phase = PH_IDLE;
								end
							end
							default: begin
								// End of the pause: begin the next group.
								seq_done = '0;
								green_lvl = 1'b1;
								seq_phase = PH_ON;
							end
						endcase
					end
				end
			end
			OP_START: begin
				seq_target = (cnt == '0) ? 8'd1 : cnt;
				seq_repeat = rep;
				seq_done = '0;
				seq_ticks = '0;
				green_lvl = 1'b1;
				seq_phase = PH_ON;
			end
			OP_GREEN: green_lvl = lvl;
			default:  red_lvl = lvl;
		endcase
		leds.green = green_lvl;
		leds.red = red_lvl;
		leds.busy = (seq_phase != PH_IDLE);
	endtask

	// Offer one item after a random gap and hold it until the transfer.
	task automatic send_item(input op_t op, input logic [CountW-1:0] cnt, input logic rep,
			input logic lvl, input logic typed, input leds_t typed_leds);
		int    gap;
		leds_t pred;
		gap = 0;
		while ($urandom_range(99) < send_gap_pct)
			gap++;
		cfg_we <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		blink_count <= cnt;
		repeat_mode <= rep;
		level <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_sequencer(op, cnt, rep, lvl, pred);
		expected_leds.push_back(typed ? typed_leds : pred);
		in_flight = 1'b1;
	endtask

	// Drop valid and hold off until every result is back and the pipeline is empty.
	task automatic drain_results();
		if (in_flight) begin
			in_valid <= 1'b0;
			while (expected_leds.size() != 0)
				@(posedge clk);
			repeat (PipeDepth + 2) @(posedge clk);
			in_flight = 1'b0;
		end
	endtask

	// Write one timing register and mirror it; the caller lowers the enable.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_ON:    on_len = data;
			CFG_OFF:   off_len = data;
			CFG_PAUSE: pause_len = data;
			default:   ;
		endcase
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0b, actual %0b", $time, name, want, got);
			errors++;
		end
	endtask

	// Result side: compare each transfer with the oldest expectation, then
	// pick the ready level for the next cycle.
	always @(posedge clk) begin : result_check
		leds_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_leds.size() == 0) begin
				$display("%0t ns: result with none expected, actual g=%0b r=%0b busy=%0b",
					$time, green_led, red_led, busy_res);
				errors++;
			end else begin
				want = expected_leds.pop_front();
				check_field("green_led", want.green, green_led);
				check_field("red_led", want.red, red_led);
				check_field("busy_res", want.busy, busy_res);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin : stimulus
		int                k;
		int                ph;
		int                n;
		logic [TickW-1:0]  on_v;
		logic [TickW-1:0]  off_v;
		logic [TickW-1:0]  pause_v;
		op_t               r_op;
		logic [CountW-1:0] r_cnt;
		int                pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling on either side.
		for (k = 0; k < NumRows; k++) begin
			if (DIRECTED[k].kind == ROW_REG) begin
				drain_results();
				write_reg(DIRECTED[k].idx, DIRECTED[k].data);
			end else begin
				send_item(DIRECTED[k].op, DIRECTED[k].cnt, DIRECTED[k].rep, DIRECTED[k].lvl,
					DIRECTED[k].typed, DIRECTED[k].leds);
			end
		end

		// Random phases: each one sets new timing and its own idling pattern.
		for (ph = 0; ph < NumPhases; ph++) begin
			drain_results();
			case (ph)
				0: begin on_v = TickW'(1); off_v = TickW'(1); pause_v = TickW'(1); end
				1: begin on_v = '0; off_v = '0; pause_v = '0; end
				2: begin
					on_v = TickW'($urandom_range(6, 1));
					off_v = TickW'($urandom_range(6, 1));
					pause_v = TickW'($urandom_range(6, 1));
				end
				3: begin on_v = TickW'(3); off_v = TickW'(5); pause_v = TickW'(2); end
				4: begin on_v = 16'hFFFF; off_v = TickW'(1); pause_v = 16'hFFFF; end
				5: begin
					on_v = TickW'($urandom_range(4));
					off_v = TickW'($urandom_range(4));
					pause_v = TickW'($urandom_range(4));
				end
				6: begin on_v = TickW'(2); off_v = '0; pause_v = TickW'(7); end
				default: begin
					on_v = TickW'($urandom_range(8, 1));
					off_v = TickW'($urandom_range(8, 1));
					pause_v = TickW'($urandom_range(8, 1));
				end
			endcase
			write_reg(CFG_ON, on_v);
			write_reg(CFG_OFF, off_v);
			write_reg(CFG_PAUSE, pause_v);

			case (ph % 4)
				0: begin send_gap_pct = 0; recv_stall_pct = 0; end
				1: begin send_gap_pct = 50; recv_stall_pct = 0; end
				2: begin send_gap_pct = 0; recv_stall_pct = 50; end
				default: begin send_gap_pct = 13; recv_stall_pct = 13; end
			endcase

			for (n = 0; n < ItemsPerPhase; n++) begin
				// Halfway through, hold the sender until the block has caught up.
				if (n == ItemsPerPhase / 2)
					drain_results();
				pick = $urandom_range(99);
				if (pick < 70)
					r_op = OP_TICK;
				else if (pick < 80)
					r_op = OP_START;
				else if (pick < 90)
					r_op = OP_GREEN;
				else
					r_op = OP_RED;
				// Mostly short groups so that group ends and pauses come around.
				case ($urandom_range(3))
					0, 1:    r_cnt = 8'($urandom_range(4));
					2:       r_cnt = 8'($urandom);
					default: r_cnt = 8'hFF;
				endcase
				send_item(r_op, r_cnt, 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'b0, '0);
			end
		end

		drain_results();
		if (errors == 0 && expected_leds.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin : watchdog
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/lbs_pkg.sv
hdl/lbs_cfg.sv
hdl/lbs_step.sv
hdl/led_blink_sequencer_core.sv
tb/sv/testbench.sv
